/* hdl/sobel_gradient_magnitude_core_assert.svh */
// ----------------------------------------------------------------------------
// Sobel gradient core assertion macros
// Shared concurrent assertion forms, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle
`define SGM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("sobel core: same-cycle check failed");

// Condition implies consequence in the next cycle
`define SGM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("sobel core: next-cycle check failed");

`endif

/* hdl/sgm_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel gradient core package
// Field widths, register codes, queue word and back end control types.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 11;
  localparam int POS_W      = 11;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_MIN    = 3;

  // gx^2 + gy^2 fits in 22 bits; the root needs 11 result bits
  localparam int SQ_W       = 22;
  localparam int ROOT_STEPS = 11;
  localparam logic [SQ_W-1:0] ROOT_START = SQ_W'(1) << (2 * (ROOT_STEPS - 1));

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One gradient word passed from front end to back end
  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic        [POS_W-1:0]  col;
    logic        [POS_W-1:0]  row;
    logic                     last;
  } grad_word_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQX,
    BK_SQY,
    BK_ROOT,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic pop;
    logic sq_first;
    logic sq_second;
    logic root_step;
    logic load;
  } bk_ctrl_t;

endpackage

`default_nettype wire

/* hdl/sgm_front.sv */
// ----------------------------------------------------------------------------
// Sobel front end
// Tracks the raster position, keeps two line stores and the 3x3 window, and
// pushes the gradients of each interior pixel into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_front import sgm_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     in_pixel,
  input  wire logic                 q_full,
  output logic                      q_push,
  output grad_word_t                q_word
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int HD_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

  logic [CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic             restart;

  logic [WD_W-1:0]  w_raw, w_eff;
  logic [HD_W-1:0]  h_raw, h_eff;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic             in_acc;

  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_a_r, rd_b_r;

  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pixel_r;
  logic [COL_W-1:0] s1_col_r;
  logic [POS_W-1:0] s1_out_col_r, s1_out_row_r;
  logic             s1_interior_r, s1_last_r;
  logic             s1_go;

  logic [PIX_W-1:0] win_r [9];
  logic [PIX_W-1:0] win_nxt [9];
  logic [PIX_W+1:0] sum_r, sum_l, sum_t, sum_b;

  // Decode register writes; any write restarts the frame
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    restart          = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_data;
          restart         = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_data;
          restart          = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    w_raw = WD_W'(frame_width_r);
    h_raw = HD_W'(frame_height_r);
    if (w_raw < WD_W'(DIM_MIN)) begin
      w_eff = WD_W'(DIM_MIN);
    end else if (w_raw > WD_W'(MAX_WIDTH)) begin
      w_eff = WD_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HD_W'(DIM_MIN)) begin
      h_eff = HD_W'(DIM_MIN);
    end else if (h_raw > HD_W'(MAX_HEIGHT)) begin
      h_eff = HD_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    last_col = COL_W'(w_eff - 1'b1);
    last_row = ROW_W'(h_eff - 1'b1);
  end

  // Stage 1 moves on unless its result has no room in the queue
  assign s1_go    = s1_valid_r && (!s1_interior_r || !q_full);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  // Advance the raster position on every accepted word; a register write resets it
  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (restart) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (in_acc) begin
      if (in_col_r == last_col) begin
        in_col_nxt = '0;
        in_row_nxt = (in_row_r == last_row) ? '0 : in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      in_col_r       <= '0;
      in_row_r       <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      s1_valid_r     <= s1_valid_nxt;
    end
  end

  // Capture the word and its position into stage 1
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r    <= in_pixel;
      s1_col_r      <= in_col_r;
      s1_out_col_r  <= POS_W'(in_col_r - 1'b1);
      s1_out_row_r  <= POS_W'(in_row_r - 1'b1);
      s1_interior_r <= (in_col_r >= COL_W'(2)) && (in_row_r >= ROW_W'(2));
      s1_last_r     <= (in_col_r == last_col) && (in_row_r == last_row);
    end
  end

  // Line stores: read on accept, write back the column when stage 1 leaves
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_a_r <= line_a[in_col_r];
      rd_b_r <= line_b[in_col_r];
    end
    if (s1_go) begin
      line_a[s1_col_r] <= s1_pixel_r;
      line_b[s1_col_r] <= rd_a_r;
    end
  end

  // Shift the window left and bring in the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3 + 0] = win_r[i*3 + 1];
      win_nxt[i*3 + 1] = win_r[i*3 + 2];
    end
    win_nxt[2] = rd_b_r;
    win_nxt[5] = rd_a_r;
    win_nxt[8] = s1_pixel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_go) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // Weighted column and row sums of the new window
  always_comb begin
    sum_r = {2'b00, win_nxt[2]} + {1'b0, win_nxt[5], 1'b0} + {2'b00, win_nxt[8]};
    sum_l = {2'b00, win_nxt[0]} + {1'b0, win_nxt[3], 1'b0} + {2'b00, win_nxt[6]};
    sum_t = {2'b00, win_nxt[0]} + {1'b0, win_nxt[1], 1'b0} + {2'b00, win_nxt[2]};
    sum_b = {2'b00, win_nxt[6]} + {1'b0, win_nxt[7], 1'b0} + {2'b00, win_nxt[8]};
  end

  assign q_push        = s1_go && s1_interior_r;
  assign q_word.grad_x = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
  assign q_word.grad_y = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
  assign q_word.col    = s1_out_col_r;
  assign q_word.row    = s1_out_row_r;
  assign q_word.last   = s1_last_r;

endmodule

`default_nettype wire

/* hdl/sgm_queue.sv */
// ----------------------------------------------------------------------------
// Sobel gradient queue
// Two-entry queue of gradient words between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_queue import sgm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire grad_word_t push_word,
  input  wire logic       pop,
  output grad_word_t      pop_word,
  output logic            full,
  output logic            empty
);

  grad_word_t  ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = ent_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

/* hdl/sgm_back.sv */
// ----------------------------------------------------------------------------
// Sobel back end
// Squares the gradients with one shared multiplier, takes the integer square
// root one result bit per cycle and holds the result word for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_back import sgm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire grad_word_t         q_word,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [GRAD_W-1:0] out_grad_x,
  output logic signed [GRAD_W-1:0] out_grad_y,
  output logic [MAG_W-1:0]        out_magnitude,
  output logic [POS_W-1:0]        out_col,
  output logic [POS_W-1:0]        out_row,
  output logic                    out_last_of_frame
);

  bk_state_t        state_r, state_nxt;
  bk_ctrl_t         ctrl;
  grad_word_t       job_r;

  logic [GRAD_W-1:0] abs_x, abs_y, mul_op;
  logic [SQ_W-1:0]   prod;
  logic [SQ_W-1:0]   acc_r, res_r, bit_r;
  logic [SQ_W-1:0]   trial;
  logic              ge;
  logic              out_free;
  logic              out_valid_r;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_SQX;
        end
      end
      BK_SQX: begin
        state_nxt = BK_SQY;
      end
      BK_SQY: begin
        state_nxt = BK_ROOT;
      end
      BK_ROOT: begin
        if (bit_r[0]) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      BK_IDLE: ctrl.pop       = !q_empty;
      BK_SQX:  ctrl.sq_first  = 1'b1;
      BK_SQY:  ctrl.sq_second = 1'b1;
      BK_ROOT: ctrl.root_step = 1'b1;
      BK_OUT:  ctrl.load      = out_free;
      default: ctrl = '0;
    endcase
  end

  assign q_pop = ctrl.pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shared multiplier on the gradient magnitudes
  assign abs_x  = job_r.grad_x[GRAD_W-1] ? GRAD_W'(-job_r.grad_x) : GRAD_W'(job_r.grad_x);
  assign abs_y  = job_r.grad_y[GRAD_W-1] ? GRAD_W'(-job_r.grad_y) : GRAD_W'(job_r.grad_y);
  assign mul_op = ctrl.sq_first ? abs_x : abs_y;
  assign prod   = SQ_W'(mul_op) * SQ_W'(mul_op);

  // One step of the digit-by-digit square root
  assign trial = res_r + bit_r;
  assign ge    = (acc_r >= trial);

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      job_r <= q_word;
    end
    if (ctrl.sq_first) begin
      acc_r <= prod;
    end else if (ctrl.sq_second) begin
      acc_r <= acc_r + prod;
      res_r <= '0;
      bit_r <= ROOT_START;
    end else if (ctrl.root_step) begin
      acc_r <= ge ? acc_r - trial : acc_r;
      res_r <= ge ? (res_r >> 1) + bit_r : res_r >> 1;
      bit_r <= bit_r >> 2;
    end
  end

  // Output register: hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_grad_x        <= job_r.grad_x;
      out_grad_y        <= job_r.grad_y;
      out_magnitude     <= MAG_W'(res_r);
      out_col           <= job_r.col;
      out_row           <= job_r.row;
      out_last_of_frame <= job_r.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/sobel_gradient_magnitude_core.sv */
// ----------------------------------------------------------------------------
// Sobel gradient magnitude core
// 3x3 Sobel edge filter on 8-bit grey frames streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_pixel takes one grey word per
//   accepted cycle, in raster order. Frame size comes from two registers
//   (frame_width at index 0, frame_height at index 1) written through
//   cfg_we / cfg_index / cfg_data while the core is idle; a write restarts
//   the frame at column 0, row 0.
//   Output channel out_valid / out_stall carries one word per interior pixel:
//   signed gradients, floor square-root magnitude, column, row and a mark on
//   the last interior word of the frame. Border pixels give no word.
//   Back end: each interior word occupies the back end for a pop, two
//   squarings, 11 square-root steps and a load; it pops the next word only
//   after loading the last one into the output register. Border pixels
//   pass the front end without entering the queue; the two-entry queue
//   lets the front end run ahead by two words.
//   Reset (rst_n low, synchronous) restores 640x480, clears position, window
//   and queue. While out_stall is high the output word holds, the back end
//   waits, and the queue then fills and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_magnitude_core import sgm_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [GRAD_W-1:0]  out_grad_x,
  output logic signed [GRAD_W-1:0]  out_grad_y,
  output logic [MAG_W-1:0]          out_magnitude,
  output logic [POS_W-1:0]          out_col,
  output logic [POS_W-1:0]          out_row,
  output logic                      out_last_of_frame
);

`include "sobel_gradient_magnitude_core_assert.svh"

  logic       q_push, q_pop, q_full, q_empty;
  grad_word_t q_push_word, q_pop_word;

  // Position tracking, line stores, window and gradients
  sgm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (q_push_word)
  );

  // Decouple front and back
  sgm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_push_word),
    .pop       (q_pop),
    .pop_word  (q_pop_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Squares, square root and output register
  sgm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_word            (q_pop_word),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_grad_x        (out_grad_x),
    .out_grad_y        (out_grad_y),
    .out_magnitude     (out_magnitude),
    .out_col           (out_col),
    .out_row           (out_row),
    .out_last_of_frame (out_last_of_frame)
  );

  // Front end never pushes into a full queue
  `SGM_ASSERT_SAME(a_push_not_full, clk, rst_n, q_push, !q_full)
  // Back end never pops an empty queue
  `SGM_ASSERT_SAME(a_pop_not_empty, clk, rst_n, q_pop, !q_empty)
  // A push into an empty queue leaves a word there next cycle
  `SGM_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push && q_empty && !q_pop, !q_empty)

endmodule

`default_nettype wire
